@@ rtl/spq_pkg.sv @@
`default_nettype none

package spq_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned COUNT_W = 5;

  localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK    = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd3;

  // Broadcast to every cell of the chain for one transaction.
  typedef struct packed {
    logic                     enq;
    logic                     deq;
    logic                     clr;
    logic signed [DATA_W-1:0] value;
  } spq_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/spq_cell.sv @@
`default_nettype none

// One slot of the sorted chain. Holds a value and an occupied flag; on
// enqueue it either keeps its value, takes the new value, or takes its left
// neighbor's value; on dequeue it takes its right neighbor's; clear empties it.
module spq_cell (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire spq_pkg::spq_ctrl_t         ctrl_i,
  input  wire logic signed [spq_pkg::DATA_W-1:0] left_val_i,
  input  wire                             left_gt_i,
  input  wire                             left_occ_i,
  input  wire logic signed [spq_pkg::DATA_W-1:0] right_val_i,
  input  wire                             right_occ_i,
  output logic signed [spq_pkg::DATA_W-1:0]      val_o,
  output logic                            occ_o,
  output logic                            gt_o
);
  import spq_pkg::*;

  logic signed [DATA_W-1:0] val_q, val_d;
  logic                     occ_q, occ_d;
  logic                     val_en;

  // Strictly greater: equal values stay ahead of the new one.
  assign gt_o  = occ_q && (val_q > ctrl_i.value);
  assign val_o = val_q;
  assign occ_o = occ_q;

  always_comb begin
    val_d  = val_q;
    occ_d  = occ_q;
    val_en = 1'b0;
    if (ctrl_i.clr) begin
      occ_d = 1'b0;
    end else if (ctrl_i.enq) begin
      occ_d = left_occ_i;
      if (gt_o || !occ_q) begin
        val_en = 1'b1;
        val_d  = left_gt_i ? left_val_i : ctrl_i.value;
      end
    end else if (ctrl_i.deq) begin
      occ_d  = right_occ_i;
      val_en = 1'b1;
      val_d  = right_val_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (val_en) begin
      val_q <= val_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sorted_priority_queue_unit.sv @@
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid_i/in_ready_o   | opcode_i, item_value_i
// out     | output    | out_valid_o/out_ready_i | ok_o, result_value_o, entry_count_o
//
// One transaction per cycle unless stalled; the result appears in the next cycle.
// Every cell of the chain updates in the cycle of acceptance, so the next
// operation sees the new order at once.
// Reset clears all occupied flags and the count; stored values are not reset.
// in_ready_o drops only while a result waits in the output register and
// out_ready_i is low.
`default_nettype none

module sorted_priority_queue_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [spq_pkg::OP_W-1:0]          opcode_i,
  input  wire logic signed [spq_pkg::DATA_W-1:0] item_value_i,
  output logic                                   out_valid_o,
  input  wire                                    out_ready_i,
  output logic                                   ok_o,
  output logic signed [spq_pkg::DATA_W-1:0]      result_value_o,
  output logic [spq_pkg::COUNT_W-1:0]            entry_count_o
);
  import spq_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic signed [DATA_W-1:0] cell_val [CAPACITY];
  logic signed [DATA_W-1:0] left_val [CAPACITY];
  logic signed [DATA_W-1:0] right_val[CAPACITY];
  logic [CAPACITY-1:0]      cell_occ, cell_gt, left_gt, left_occ, right_occ;

  spq_ctrl_t                ctrl;
  logic                     accept, full, empty;
  logic                     ok_d;
  logic signed [DATA_W-1:0] res_d;
  logic [CW-1:0]            count_q, count_d;

  logic                     out_valid_q;
  logic                     ok_q;
  logic signed [DATA_W-1:0] res_q;
  logic [COUNT_W-1:0]       cnt_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = cell_occ[CAPACITY-1];
  assign empty      = !cell_occ[0];

  assign ctrl.enq   = accept && (opcode_i == OP_ENQUEUE) && !full;
  assign ctrl.deq   = accept && (opcode_i == OP_DEQUEUE) && !empty;
  assign ctrl.clr   = accept && (opcode_i == OP_CLEAR);
  assign ctrl.value = item_value_i;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_val[i] = '0;
      assign left_gt[i]  = 1'b0;
      assign left_occ[i] = 1'b1;
    end else begin : g_body
      assign left_val[i] = cell_val[i-1];
      assign left_gt[i]  = cell_gt[i-1];
      assign left_occ[i] = cell_occ[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_val[i] = cell_val[i];
      assign right_occ[i] = 1'b0;
    end else begin : g_inner
      assign right_val[i] = cell_val[i+1];
      assign right_occ[i] = cell_occ[i+1];
    end

    spq_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .left_val_i (left_val[i]),
      .left_gt_i  (left_gt[i]),
      .left_occ_i (left_occ[i]),
      .right_val_i(right_val[i]),
      .right_occ_i(right_occ[i]),
      .val_o      (cell_val[i]),
      .occ_o      (cell_occ[i]),
      .gt_o       (cell_gt[i])
    );
  end

  always_comb begin
    ok_d    = 1'b0;
    res_d   = '0;
    count_d = count_q;
    case (opcode_i)
      OP_ENQUEUE: begin
        ok_d = !full;
        if (!full) begin
          count_d = count_q + CW'(1);
        end
      end
      OP_DEQUEUE: begin
        ok_d = !empty;
        if (!empty) begin
          res_d   = cell_val[0];
          count_d = count_q - CW'(1);
        end
      end
      OP_PEEK: begin
        ok_d = !empty;
        if (!empty) begin
          res_d = cell_val[0];
        end
      end
      OP_CLEAR: begin
        ok_d    = !empty;
        count_d = '0;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q  <= ok_d;
      res_q <= res_d;
      cnt_q <= COUNT_W'((CW + COUNT_W)'(count_d));
    end
  end

  assign out_valid_o    = out_valid_q;
  assign ok_o           = ok_q;
  assign result_value_o = res_q;
  assign entry_count_o  = cnt_q;

endmodule

`default_nettype wire

@@ rtl/spq_checker.sv @@
`default_nettype none

module spq_checker (
  input wire                                    clk_i,
  input wire                                    rst_ni,
  input wire                                    in_valid_i,
  input wire                                    in_ready_o,
  input wire logic [spq_pkg::OP_W-1:0]          opcode_i,
  input wire                                    out_valid_o,
  input wire                                    out_ready_i,
  input wire                                    ok_o,
  input wire logic signed [spq_pkg::DATA_W-1:0] result_value_o,
  input wire logic [spq_pkg::COUNT_W-1:0]       entry_count_o
);
  import spq_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(ok_o)
      && $stable(result_value_o) && $stable(entry_count_o))
    else $error("stalled result changed");

  // Every transaction yields a result in the next cycle.
  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (opcode_i == OP_CLEAR) |=> out_valid_o && (entry_count_o == '0))
    else $error("clear did not empty the queue");

  a_enq_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (opcode_i == OP_ENQUEUE) |=> out_valid_o && (result_value_o == '0))
    else $error("enqueue result value not zero");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (opcode_i == OP_PEEK || opcode_i == OP_DEQUEUE)
      |=> out_valid_o && (ok_o || (result_value_o == '0)))
    else $error("failed read returned a value");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .opcode_i      (opcode_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .ok_o          (ok_o),
  .result_value_o(result_value_o),
  .entry_count_o (entry_count_o)
);

`default_nettype wire
